/* rtl/core/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is high.
`define ASSERT_IMPLY_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/dbds_pkg.sv */
`default_nettype none

package dbds_pkg;

   // Fixed field widths
   localparam int unsigned FIELD_ADDR_W = 64;
   localparam int unsigned LEN_W        = 23;
   localparam int unsigned BEATS_M1_W   = 22;
   localparam int unsigned WIDTH_W      = 3;
   localparam int unsigned PROBE_W      = 7;   // beat width never exceeds 2^6 bytes

   localparam int unsigned ADDR_WIDTH_DEFAULT = 64;

   // Saturation limits
   localparam logic [LEN_W-1:0]   LEN_CAP   = 23'd4194304;
   localparam logic [LEN_W-1:0]   BEATS_MIN = 23'd65536;
   localparam logic [LEN_W-1:0]   BEATS_MAX = 23'd4194304;
   localparam logic [WIDTH_W-1:0] BW_MAX    = 3'd6;

   // Register indexes
   localparam logic [1:0] REG_BUS_WIDTH  = 2'd0;
   localparam logic [1:0] REG_MAX_BEATS  = 2'd1;
   localparam logic [1:0] REG_DIRECTION  = 2'd2;
   localparam logic [1:0] REG_TWO_MASTER = 2'd3;

   // Transfer direction codes
   localparam logic [1:0] DIR_MEM_TO_MEM = 2'd0;
   localparam logic [1:0] DIR_MEM_TO_DEV = 2'd1;
   localparam logic [1:0] DIR_DEV_TO_MEM = 2'd2;
   localparam logic [1:0] DIR_DEV_TO_DEV = 2'd3;

   // Address mode and master select
   localparam logic ADDR_INCR     = 1'b0;
   localparam logic ADDR_FIXED    = 1'b1;
   localparam logic MASTER_FIRST  = 1'b0;
   localparam logic MASTER_SECOND = 1'b1;

   // One block worked out by the chunk unit
   typedef struct packed {
      logic [WIDTH_W-1:0]    width_log2;
      logic [BEATS_M1_W-1:0] beats_m1;
      logic [LEN_W-1:0]      bytes;
      logic [LEN_W-1:0]      remaining;
   } chunk_type;

endpackage

`default_nettype wire

/* rtl/core/dbds_chunk.sv */
`default_nettype none

// Sizes one block: beat width from the alignment probe, clamped beat count,
// byte count and what is left of the request.
module dbds_chunk (
   input  wire logic [dbds_pkg::PROBE_W-1:0] src_lo,
   input  wire logic [dbds_pkg::PROBE_W-1:0] dst_lo,
   input  wire logic [dbds_pkg::LEN_W-1:0]   len,
   input  wire logic [dbds_pkg::WIDTH_W-1:0] bus_width,   // already clamped to 6
   input  wire logic [dbds_pkg::LEN_W-1:0]   max_beats,   // already clamped
   output dbds_pkg::chunk_type               chunk
);

   logic [dbds_pkg::PROBE_W-1:0] probe;
   logic [dbds_pkg::WIDTH_W-1:0] w;
   logic [dbds_pkg::LEN_W-1:0]   beats;
   logic [dbds_pkg::LEN_W-1:0]   bytes;

   always_comb begin
      probe = src_lo | dst_lo | len[dbds_pkg::PROBE_W-1:0]
            | (dbds_pkg::PROBE_W'(1) << bus_width);
      // lowest set bit; bus width bit guarantees one within range
      w = '0;
      for (int i = dbds_pkg::PROBE_W - 1; i >= 0; i--) begin
         if (probe[i]) begin
            w = dbds_pkg::WIDTH_W'(i);
         end
      end
      beats = len >> w;
      if (beats > max_beats) begin
         beats = max_beats;
      end
      bytes = beats << w;

      chunk.width_log2 = w;
      chunk.beats_m1   = dbds_pkg::BEATS_M1_W'(beats - dbds_pkg::LEN_W'(1));
      chunk.bytes      = bytes;
      chunk.remaining  = len - bytes;
   end

endmodule

`default_nettype wire

/* rtl/core/dma_block_descriptor_splitter.sv */
`default_nettype none

// Channel   Dir  Handshake          Payload
// req_      in   tvalid/tready      copy request (source, destination, length)
// rsp_      out  tvalid/tready      block descriptor, tlast on final block
// csr_      in   APB psel/penable   four config registers at 0x0/0x4/0x8/0xC
//
// A request is taken while the sequencer is idle; each block then goes through
// three steps: size it and load the output register, then advance the source
// and the destination address through the one shared address adder. A request
// of zero length emits nothing. Synchronous active-high reset clears the
// sequencer, output valid and the config registers to their defaults. A
// stalled rsp_ holds the sequencer in the sizing step; the next request is
// taken once the last block's addresses have advanced.

module dma_block_descriptor_splitter #(
   parameter int unsigned ADDR_WIDTH = dbds_pkg::ADDR_WIDTH_DEFAULT  // 32..64
) (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [63:0] source_address, [127:64] dest_address, [150:128] byte_length, [151] zero
   input  wire logic [151:0] req_tdata,

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [63:0] chunk_source, [127:64] chunk_dest, [149:128] beats_minus_one,
   // [152:150] width_log2, [153] source_fixed, [154] dest_fixed,
   // [155] dest_master, [159:156] zero
   output logic [159:0]      rsp_tdata,
   output logic              rsp_tlast,   // last_block

   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

`include "assert_macros.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHUNK,
      ST_ADV_SRC,
      ST_ADV_DST
   } state_type;

   // Config registers
   logic [dbds_pkg::WIDTH_W-1:0] bw_cfg_ff,   bw_cfg_in;
   logic [dbds_pkg::LEN_W-1:0]   maxb_cfg_ff, maxb_cfg_in;
   logic [1:0]                   dir_cfg_ff,  dir_cfg_in;
   logic                         two_cfg_ff,  two_cfg_in;

   // Sequencer and working state
   state_type                    state_ff, state_in;
   logic [ADDR_WIDTH-1:0]        src_ff,   src_in;
   logic [ADDR_WIDTH-1:0]        dst_ff,   dst_in;
   logic [dbds_pkg::LEN_W-1:0]   len_ff,   len_in;
   logic [dbds_pkg::LEN_W-1:0]   bytes_ff, bytes_in;

   // Output register
   logic                            out_valid_ff, out_valid_in;
   logic [ADDR_WIDTH-1:0]           out_src_ff,   out_src_in;
   logic [ADDR_WIDTH-1:0]           out_dst_ff,   out_dst_in;
   logic [dbds_pkg::BEATS_M1_W-1:0] beats_m1_ff,  beats_m1_in;
   logic [dbds_pkg::WIDTH_W-1:0]    width_ff,     width_in;
   logic                            sfix_ff,      sfix_in;
   logic                            dfix_ff,      dfix_in;
   logic                            dmaster_ff,   dmaster_in;
   logic                            last_ff,      last_in;

   logic                         cfg_wr;
   logic                         in_take;
   logic                         rsp_take;
   logic                         load;
   logic [dbds_pkg::WIDTH_W-1:0] bw_eff;
   logic [dbds_pkg::LEN_W-1:0]   maxb_eff;
   logic [dbds_pkg::LEN_W-1:0]   req_len;
   logic [ADDR_WIDTH-1:0]        add_a;
   logic [ADDR_WIDTH-1:0]        addr_sum;
   logic [dbds_pkg::FIELD_ADDR_W-1:0] out_src_ext;
   logic [dbds_pkg::FIELD_ADDR_W-1:0] out_dst_ext;
   logic [dbds_pkg::LEN_W-1:0]   out_beats;
   dbds_pkg::chunk_type          chunk;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      bw_cfg_in   = bw_cfg_ff;
      maxb_cfg_in = maxb_cfg_ff;
      dir_cfg_in  = dir_cfg_ff;
      two_cfg_in  = two_cfg_ff;
      if (cfg_wr) begin
         unique case (csr_paddr[3:2])
            dbds_pkg::REG_BUS_WIDTH:  bw_cfg_in   = csr_pwdata[dbds_pkg::WIDTH_W-1:0];
            dbds_pkg::REG_MAX_BEATS:  maxb_cfg_in = csr_pwdata[dbds_pkg::LEN_W-1:0];
            dbds_pkg::REG_DIRECTION:  dir_cfg_in  = csr_pwdata[1:0];
            dbds_pkg::REG_TWO_MASTER: two_cfg_in  = csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         dbds_pkg::REG_BUS_WIDTH:  csr_prdata = 32'(bw_cfg_ff);
         dbds_pkg::REG_MAX_BEATS:  csr_prdata = 32'(maxb_cfg_ff);
         dbds_pkg::REG_DIRECTION:  csr_prdata = 32'(dir_cfg_ff);
         dbds_pkg::REG_TWO_MASTER: csr_prdata = 32'(two_cfg_ff);
      endcase
   end

   // Out-of-range settings saturate
   assign bw_eff   = (bw_cfg_ff > dbds_pkg::BW_MAX) ? dbds_pkg::BW_MAX : bw_cfg_ff;
   assign maxb_eff = (maxb_cfg_ff < dbds_pkg::BEATS_MIN) ? dbds_pkg::BEATS_MIN :
                     (maxb_cfg_ff > dbds_pkg::BEATS_MAX) ? dbds_pkg::BEATS_MAX :
                     maxb_cfg_ff;

   // ------------------------------------------------------------ block sizing
   dbds_chunk u_chunk (
      .src_lo    (src_ff[dbds_pkg::PROBE_W-1:0]),
      .dst_lo    (dst_ff[dbds_pkg::PROBE_W-1:0]),
      .len       (len_ff),
      .bus_width (bw_eff),
      .max_beats (maxb_eff),
      .chunk     (chunk)
   );

   // Shared address adder: source in one step, destination in the next
   assign add_a    = (state_ff == ST_ADV_SRC) ? src_ff : dst_ff;
   assign addr_sum = add_a + ADDR_WIDTH'(bytes_ff);

   // -------------------------------------------------------------- sequencer
   assign req_tready = (state_ff == ST_IDLE);
   assign in_take    = req_tvalid & req_tready;
   assign rsp_take   = out_valid_ff & rsp_tready;
   assign load       = (state_ff == ST_CHUNK) & (~out_valid_ff | rsp_tready);
   assign req_len    = (req_tdata[150:128] > dbds_pkg::LEN_CAP) ? dbds_pkg::LEN_CAP
                                                               : req_tdata[150:128];

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      len_in       = len_ff;
      bytes_in     = bytes_ff;
      out_valid_in = out_valid_ff & ~rsp_take;
      out_src_in   = out_src_ff;
      out_dst_in   = out_dst_ff;
      beats_m1_in  = beats_m1_ff;
      width_in     = width_ff;
      sfix_in      = sfix_ff;
      dfix_in      = dfix_ff;
      dmaster_in   = dmaster_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_take) begin
               src_in = req_tdata[ADDR_WIDTH-1:0];
               dst_in = req_tdata[64 +: ADDR_WIDTH];
               len_in = req_len;
               if (req_len != '0) begin
                  state_in = ST_CHUNK;
               end
            end
         end
         ST_CHUNK: begin
            if (load) begin
               out_valid_in = 1'b1;
               out_src_in   = src_ff;
               out_dst_in   = dst_ff;
               beats_m1_in  = chunk.beats_m1;
               width_in     = chunk.width_log2;
               sfix_in      = (dir_cfg_ff == dbds_pkg::DIR_DEV_TO_MEM ||
                               dir_cfg_ff == dbds_pkg::DIR_DEV_TO_DEV) ?
                              dbds_pkg::ADDR_FIXED : dbds_pkg::ADDR_INCR;
               dfix_in      = (dir_cfg_ff == dbds_pkg::DIR_MEM_TO_DEV ||
                               dir_cfg_ff == dbds_pkg::DIR_DEV_TO_DEV) ?
                              dbds_pkg::ADDR_FIXED : dbds_pkg::ADDR_INCR;
               dmaster_in   = two_cfg_ff ? dbds_pkg::MASTER_SECOND : dbds_pkg::MASTER_FIRST;
               last_in      = (chunk.remaining == '0);
               len_in       = chunk.remaining;
               bytes_in     = chunk.bytes;
               state_in     = ST_ADV_SRC;
            end
         end
         ST_ADV_SRC: begin
            src_in   = addr_sum;
            state_in = ST_ADV_DST;
         end
         ST_ADV_DST: begin
            dst_in   = addr_sum;
            state_in = (len_ff == '0) ? ST_IDLE : ST_CHUNK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         bw_cfg_ff    <= 3'd2;
         maxb_cfg_ff  <= dbds_pkg::BEATS_MIN;
         dir_cfg_ff   <= dbds_pkg::DIR_MEM_TO_MEM;
         two_cfg_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         bw_cfg_ff    <= bw_cfg_in;
         maxb_cfg_ff  <= maxb_cfg_in;
         dir_cfg_ff   <= dir_cfg_in;
         two_cfg_ff   <= two_cfg_in;
      end
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      len_ff      <= len_in;
      bytes_ff    <= bytes_in;
      out_src_ff  <= out_src_in;
      out_dst_ff  <= out_dst_in;
      beats_m1_ff <= beats_m1_in;
      width_ff    <= width_in;
      sfix_ff     <= sfix_in;
      dfix_ff     <= dfix_in;
      dmaster_ff  <= dmaster_in;
      last_ff     <= last_in;
   end

   // ---------------------------------------------------------------- outputs
   assign out_src_ext = dbds_pkg::FIELD_ADDR_W'(out_src_ff);
   assign out_dst_ext = dbds_pkg::FIELD_ADDR_W'(out_dst_ff);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {4'b0, dmaster_ff, dfix_ff, sfix_ff, width_ff, beats_m1_ff,
                        out_dst_ext, out_src_ext};

   // ------------------------------------------------------------- assertions
   assign out_beats = dbds_pkg::LEN_W'(beats_m1_ff) + dbds_pkg::LEN_W'(1);

   // Last flag tracks what is left of the request after the block just loaded
   `ASSERT_IMPLY_NEXT(a_last_matches_len, clock, reset, load, rsp_tlast == (len_ff == '0))
   // Beat width never exceeds the effective bus width
   `ASSERT_IMPLY(a_width_in_bus, clock, reset, rsp_tvalid, width_ff <= bw_eff)
   // Only a full-size block can leave bytes behind
   `ASSERT_IMPLY(a_mid_block_full, clock, reset, rsp_tvalid && !rsp_tlast, out_beats == maxb_eff)

endmodule

`default_nettype wire
